>>> rtl/sas_pkg.sv
// Shared types and constants for the speaker activity segmenter.
package sas_pkg;

  localparam int OUT_FRAME_W = 16;  // frame numbers on the result port
  localparam int SPK_W       = 3;   // speaker number on the result port
  localparam int CFG_W       = 16;  // widest configuration register
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_MIN_LEN   = 2'd1,
    CFG_GAP_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] threshold;
    logic [CFG_W-1:0]        min_len;
    logic [CFG_W-1:0]        gap_limit;
  } cfg_t;

  // One candidate segment from a lane.
  typedef struct packed {
    logic                   vld;
    logic [OUT_FRAME_W-1:0] start;
    logic [OUT_FRAME_W-1:0] stop;
  } seg_t;

endpackage

>>> rtl/sas_if.sv
// Frame input and segment output channel interfaces.
interface sas_in_if #(
  parameter int NUM_SPEAKERS = 7,
  parameter int SCORE_BITS   = 16
);
  logic                               valid;
  logic                               ready;
  logic [NUM_SPEAKERS*SCORE_BITS-1:0] score;  // speaker s at [s*SCORE_BITS +: SCORE_BITS]
  logic                               last_frame;

  modport source (output valid, score, last_frame, input ready);
  modport sink   (input valid, score, last_frame, output ready);
endinterface

interface sas_out_if;
  logic                            valid;
  logic                            ready;
  logic [sas_pkg::SPK_W-1:0]       speaker;
  logic [sas_pkg::OUT_FRAME_W-1:0] start_frame;
  logic [sas_pkg::OUT_FRAME_W-1:0] end_frame;
  logic                            run_end;

  modport source (output valid, speaker, start_frame, end_frame, run_end, input ready);
  modport sink   (input valid, speaker, start_frame, end_frame, run_end, output ready);
endinterface

>>> rtl/sas_lane.sv
// One speaker lane: threshold, run tracking, held segment merge and flush.
module sas_lane #(
  parameter int FRAME_BITS = 16,
  parameter int SCORE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,    // frame accepted this edge
  input  logic                         last,
  input  logic signed [SCORE_BITS-1:0] score,
  input  sas_pkg::cfg_t                cfg,
  input  logic [FRAME_BITS-1:0]        frame,   // index of the frame being taken
  input  logic [FRAME_BITS-1:0]        count,   // frame count of the staged frame
  output sas_pkg::seg_t                t_seg,   // emitted by a run closing
  output sas_pkg::seg_t                c_seg,   // emitted by closing an open run at chunk end
  output sas_pkg::seg_t                h_seg    // held segment flushed at chunk end
);
  import sas_pkg::*;

  localparam int CW = (FRAME_BITS > CFG_W) ? FRAME_BITS : CFG_W;
  localparam int SW = (SCORE_BITS > CFG_W) ? SCORE_BITS : CFG_W;

  // saturating difference hi - lo, zero when reversed
  function automatic logic [CW-1:0] span(input logic [FRAME_BITS-1:0] hi,
                                         input logic [FRAME_BITS-1:0] lo);
    logic [FRAME_BITS-1:0] d;
    d = hi - lo;
    span = (hi >= lo) ? CW'(d) : '0;
  endfunction

  function automatic logic [OUT_FRAME_W-1:0] trunc(input logic [FRAME_BITS-1:0] x);
    trunc = OUT_FRAME_W'({{OUT_FRAME_W{1'b0}}, x});
  endfunction

  // lane state
  logic                  run_active;
  logic                  held_valid;
  logic [FRAME_BITS-1:0] run_start;
  logic [FRAME_BITS-1:0] held_start;
  logic [FRAME_BITS-1:0] held_end;

  // staged post-transition view
  logic                  a_last;
  logic                  a_ra;
  logic                  a_hv;
  logic [FRAME_BITS-1:0] a_rs;
  logic [FRAME_BITS-1:0] a_hs;
  logic [FRAME_BITS-1:0] a_he;
  seg_t                  a_t;

  logic signed [SW-1:0]  sc_x;
  logic signed [SW-1:0]  th_x;
  logic [CW-1:0]         mg_x;
  logic [CW-1:0]         min_x;
  logic                  act;
  logic                  close;
  logic                  mrg_t;
  logic                  ok_t;
  logic                  hv1;
  logic [FRAME_BITS-1:0] rs1;
  logic [FRAME_BITS-1:0] hs1;
  logic [FRAME_BITS-1:0] he1;
  logic                  mrg_c;
  logic                  ok_held;
  logic                  ok_h2;

  assign sc_x  = SW'(score);
  assign th_x  = SW'(cfg.threshold);
  assign mg_x  = CW'(cfg.gap_limit);
  assign min_x = CW'(cfg.min_len);
  assign act   = (sc_x >= th_x);

  // transition of this frame; the gap runs from the held end to the run start
  assign close = run_active && !act;
  assign mrg_t = held_valid && (span(run_start, held_end) <= mg_x);
  assign ok_t  = span(held_end, held_start) >= min_x;
  assign rs1   = (!run_active && act) ? frame : run_start;
  assign hv1   = held_valid || close;
  assign hs1   = (close && !mrg_t) ? run_start : held_start;
  assign he1   = close ? frame : held_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      held_valid <= 1'b0;
    end else if (take) begin
      run_active <= act && !last;
      held_valid <= hv1 && !last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      run_start <= rs1;
      held_start <= hs1;
      held_end <= he1;
      a_last <= last;
      a_ra <= act;
      a_hv <= hv1;
      a_rs <= rs1;
      a_hs <= hs1;
      a_he <= he1;
      a_t.vld <= close && held_valid && !mrg_t && ok_t;
      a_t.start <= trunc(held_start);
      a_t.stop <= trunc(held_end);
    end
  end

  // chunk-end close and flush on the staged view
  assign mrg_c   = a_hv && (span(a_rs, a_he) <= mg_x);
  assign ok_held = span(a_he, a_hs) >= min_x;

  always_comb begin
    ok_h2 = ok_held;
    if (a_ra) begin
      ok_h2 = (mrg_c ? span(count, a_hs) : span(count, a_rs)) >= min_x;
    end
  end

  always_comb begin
    t_seg = a_t;
    c_seg.vld = a_last && a_ra && a_hv && !mrg_c && ok_held;
    c_seg.start = trunc(a_hs);
    c_seg.stop = trunc(a_he);
    h_seg.vld = a_last && (a_hv || a_ra) && ok_h2;
    h_seg.start = (a_ra && !mrg_c) ? trunc(a_rs) : trunc(a_hs);
    h_seg.stop = a_ra ? trunc(count) : trunc(a_he);
  end

endmodule

>>> rtl/sas_merge.sv
// Merge stage: holds one frame's candidate segments and sends them out in order.
module sas_merge #(
  parameter int NUM_SPEAKERS = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sas_pkg::seg_t    slot_in [3*NUM_SPEAKERS],
  output logic             batch_free,
  sas_out_if.source        seg_out
);
  import sas_pkg::*;

  localparam int NSLOT = 3 * NUM_SPEAKERS;

  // slot order: closes of all speakers, then close/flush pairs per speaker
  function automatic logic [SPK_W-1:0] slot_spk(input int i);
    slot_spk = (i < NUM_SPEAKERS) ? SPK_W'(i) : SPK_W'((i - NUM_SPEAKERS) >> 1);
  endfunction

  logic [NSLOT-1:0]       bvld;
  seg_t                   bseg [NSLOT];
  logic [NSLOT-1:0]       new_vld;
  logic [NSLOT-1:0]       low;
  logic [NSLOT-1:0]       rest;
  logic                   any;
  logic                   move;
  logic                   ovalid;
  logic [SPK_W-1:0]       pk_spk;
  logic [OUT_FRAME_W-1:0] pk_start;
  logic [OUT_FRAME_W-1:0] pk_stop;

  assign low  = bvld & (~bvld + NSLOT'(1));
  assign rest = bvld & ~low;
  assign any  = |bvld;
  assign move = any && (!ovalid || seg_out.ready);
  assign batch_free = !any || (move && (rest == '0));

  always_comb begin
    for (int i = 0; i < NSLOT; i++) begin
      new_vld[i] = slot_in[i].vld;
    end
  end

  always_comb begin
    pk_spk = '0;
    pk_start = '0;
    pk_stop = '0;
    for (int i = 0; i < NSLOT; i++) begin
      pk_spk = pk_spk | ({SPK_W{low[i]}} & slot_spk(i));
      pk_start = pk_start | ({OUT_FRAME_W{low[i]}} & bseg[i].start);
      pk_stop = pk_stop | ({OUT_FRAME_W{low[i]}} & bseg[i].stop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvld <= '0;
    end else if (load) begin
      bvld <= new_vld;
    end else if (move) begin
      bvld <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bseg <= slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (move) begin
      ovalid <= 1'b1;
    end else if (seg_out.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      seg_out.speaker <= pk_spk;
      seg_out.start_frame <= pk_start;
      seg_out.end_frame <= pk_stop;
      seg_out.run_end <= (rest == '0);
    end
  end

  assign seg_out.valid = ovalid;

endmodule

>>> rtl/speaker_activity_segmenter.sv
// Top level: per-speaker lanes, frame counter, configuration and result merge.
//
//  port       dir  handshake      payload
//  frame_in   in   valid/ready    score (one slice per speaker), last_frame
//  seg_out    out  valid/ready    speaker, start_frame, end_frame, run_end
//  cfg_*      in   cfg_we only    cfg_idx selects register, cfg_wdata value
//
// Lanes judge a taken frame in parallel and stage their candidates; once the
// merge buffer is free they load into it, and it sends one segment per cycle
// while seg_out is ready. A frame with results holds the buffer until all are
// sent, and the next frame waits; frames without results pass at one per
// cycle. The first result passes the lane stage, merge buffer and output
// register. Reset (rst, synchronous) clears the counter, lanes, buffer and
// registers. A stalled seg_out holds the buffer and, through it, frame_in.
module speaker_activity_segmenter #(
  parameter int NUM_SPEAKERS = 7,
  parameter int FRAME_BITS   = 16,
  parameter int SCORE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sas_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sas_pkg::CFG_W-1:0]     cfg_wdata,
  sas_in_if.sink                        frame_in,
  sas_out_if.source                     seg_out
);
  import sas_pkg::*;

  localparam int NSLOT = 3 * NUM_SPEAKERS;

  cfg_t                  cfg;
  logic [FRAME_BITS-1:0] frame_index;
  logic [FRAME_BITS-1:0] frame_inc;
  logic [FRAME_BITS-1:0] a_count;    // frame count for the staged frame
  logic                  a_vld;      // lanes hold a staged frame
  logic                  in_fire;
  logic                  load;
  logic                  batch_free;

  seg_t t_segs [NUM_SPEAKERS];
  seg_t c_segs [NUM_SPEAKERS];
  seg_t h_segs [NUM_SPEAKERS];
  seg_t slots  [NSLOT];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_THRESHOLD: cfg.threshold <= cfg_wdata;
        CFG_MIN_LEN:   cfg.min_len <= cfg_wdata;
        CFG_GAP_LIMIT: cfg.gap_limit <= cfg_wdata;
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // frame counter saturates at all ones
  assign frame_inc = (&frame_index) ? frame_index : frame_index + 1'b1;

  // staged frame leaves the lanes once the merge buffer can take it
  assign load    = a_vld && batch_free;
  assign frame_in.ready = !a_vld || batch_free;
  assign in_fire = frame_in.valid && frame_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index <= '0;
      a_vld <= 1'b0;
    end else begin
      if (in_fire) begin
        frame_index <= frame_in.last_frame ? '0 : frame_inc;
      end
      if (in_fire) begin
        a_vld <= 1'b1;
      end else if (batch_free) begin
        a_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_count <= frame_inc;
    end
  end

  for (genvar s = 0; s < NUM_SPEAKERS; s++) begin : g_lane
    sas_lane #(
      .FRAME_BITS (FRAME_BITS),
      .SCORE_BITS (SCORE_BITS)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .take  (in_fire),
      .last  (frame_in.last_frame),
      .score (frame_in.score[s*SCORE_BITS +: SCORE_BITS]),
      .cfg   (cfg),
      .frame (frame_index),
      .count (a_count),
      .t_seg (t_segs[s]),
      .c_seg (c_segs[s]),
      .h_seg (h_segs[s])
    );

    // run closes first for all speakers, then chunk-end pairs per speaker
    assign slots[s] = t_segs[s];
    assign slots[NUM_SPEAKERS + 2*s] = c_segs[s];
    assign slots[NUM_SPEAKERS + 2*s + 1] = h_segs[s];
  end

  sas_merge #(
    .NUM_SPEAKERS (NUM_SPEAKERS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .slot_in    (slots),
    .batch_free (batch_free),
    .seg_out    (seg_out)
  );

  // counter advances by one per ordinary frame, holding at its maximum
  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && !frame_in.last_frame |=>
      (frame_index == $past(frame_index) + 1'b1) ||
      ((&frame_index) && (&$past(frame_index))))
    else $error("frame counter did not advance");

  // chunk end restarts the frame count
  a_chunk_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && frame_in.last_frame |=> frame_index == '0)
    else $error("frame counter not cleared at chunk end");

  // a staged frame that cannot move on must block the input
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_vld && !batch_free && !in_fire |=> a_vld && (a_count == $past(a_count)))
    else $error("staged frame lost while merge buffer busy");

endmodule

>>> test/tb_speaker_activity_segmenter.sv
// Self-checking testbench for the speaker activity segmenter: random and directed frames.
module tb_speaker_activity_segmenter;
  import sas_pkg::*;

  localparam int NUM_SPK       = 7;
  localparam int SCORE_W       = 16;
  localparam int SETTLE_CYCLES = 8;          // idle margin after the result path drains
  localparam int QUEUE_DEPTH   = 16;         // pending frames ahead of the driver
  localparam int LIMIT_TIME    = 8_000_000;  // watchdog limit on simulation time

  // Index past the end of the register list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [NUM_SPK-1:0][SCORE_W-1:0] score;  // lane s sits at [s*SCORE_W +: SCORE_W]
    logic                            chunk_end;
  } frame_t;

  typedef struct packed {
    logic [SPK_W-1:0]       speaker;
    logic [OUT_FRAME_W-1:0] start_frame;
    logic [OUT_FRAME_W-1:0] end_frame;
    logic                   run_end;
  } seg_rec_t;

  // Receiver pacing modes.
  typedef enum int {PACE_FREE, PACE_COIN, PACE_SPARSE, PACE_BURSTY} pace_t;

  logic clk;
  logic rst = 1'b1;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Local copies of the channel controls so every input is known from time zero.
  logic   in_valid  = 1'b0;
  frame_t in_frame  = '0;
  logic   out_ready = 1'b0;
  logic   in_taken  = 1'b0;

  sas_in_if #(.NUM_SPEAKERS(NUM_SPK), .SCORE_BITS(SCORE_W)) frame_ch ();
  sas_out_if seg_ch ();

  assign frame_ch.valid      = in_valid;
  assign frame_ch.score      = in_frame.score;
  assign frame_ch.last_frame = in_frame.chunk_end;
  assign seg_ch.ready        = out_ready;

  speaker_activity_segmenter #(
    .NUM_SPEAKERS(NUM_SPK),
    .FRAME_BITS  (16),
    .SCORE_BITS  (SCORE_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .frame_in (frame_ch),
    .seg_out  (seg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Segment predictor. Mirrors the block's lanes: per speaker one open run and
  // one held segment waiting for a merge. Updated only at accepted frames and
  // register writes, from the checker process.
  // ---------------------------------------------------------------------------
  logic signed [CFG_W-1:0] thr_q;
  logic [CFG_W-1:0]        min_len_q;
  logic [CFG_W-1:0]        gap_max_q;

  logic [OUT_FRAME_W-1:0] frame_cnt;
  bit                     run_on     [NUM_SPK];
  logic [OUT_FRAME_W-1:0] run_begin  [NUM_SPK];
  bit                     hold_on    [NUM_SPK];
  logic [OUT_FRAME_W-1:0] hold_begin [NUM_SPK];
  logic [OUT_FRAME_W-1:0] hold_stop  [NUM_SPK];

  seg_rec_t frame_segs[$];   // segments caused by the frame being predicted
  seg_rec_t seg_exp_q[$];    // segments still owed by the block, oldest first

  int frames_queued = 0;
  int frames_taken  = 0;
  int fails         = 0;

  // Frame counter sticks at all ones.
  function automatic logic [OUT_FRAME_W-1:0] frame_bump(input logic [OUT_FRAME_W-1:0] f);
    return (f == '1) ? f : f + 1'b1;
  endfunction

  task automatic clear_lanes();
    frame_cnt = '0;
    for (int s = 0; s < NUM_SPK; s++) begin
      run_on[s]     = 1'b0;
      run_begin[s]  = '0;
      hold_on[s]    = 1'b0;
      hold_begin[s] = '0;
      hold_stop[s]  = '0;
    end
  endtask

  // Held segment leaves the lane; only long enough ones are reported.
  task automatic release_held(input int s);
    logic [OUT_FRAME_W-1:0] len;
    seg_rec_t               rec;
    len = (hold_stop[s] < hold_begin[s]) ? '0 : hold_stop[s] - hold_begin[s];
    if (len >= min_len_q) begin
      rec.speaker     = SPK_W'(s);
      rec.start_frame = hold_begin[s];
      rec.end_frame   = hold_stop[s];
      rec.run_end     = 1'b0;
      frame_segs.insert(frame_segs.size(), rec);
    end
  endtask

  // A closed run either extends the held segment or replaces it.
  task automatic fold_run(input int s, input logic [OUT_FRAME_W-1:0] start,
                          input logic [OUT_FRAME_W-1:0] stop);
    logic [OUT_FRAME_W-1:0] gap;
    bit                     merged;
    merged = 1'b0;
    if (hold_on[s]) begin
      // a start before the held end can only come from saturation: no gap
      gap = (start >= hold_stop[s]) ? start - hold_stop[s] : '0;
      if (gap <= gap_max_q) begin
        hold_stop[s] = stop;
        merged       = 1'b1;
      end else begin
        release_held(s);
      end
    end
    if (!merged) begin
      hold_on[s]    = 1'b1;
      hold_begin[s] = start;
      hold_stop[s]  = stop;
    end
  endtask

  task automatic predict_segments(input frame_t fr);
    logic [OUT_FRAME_W-1:0] f;
    logic [OUT_FRAME_W-1:0] count;
    bit                     act;
    seg_rec_t               rec;
    frame_segs.delete();
    f = frame_cnt;
    // transitions first, in speaker order
    for (int s = 0; s < NUM_SPK; s++) begin
      act = $signed(fr.score[s]) >= thr_q;
      if (run_on[s]) begin
        if (!act) begin
          run_on[s] = 1'b0;
          fold_run(s, run_begin[s], f);
        end
      end else if (act) begin
        run_on[s]    = 1'b1;
        run_begin[s] = f;
      end
    end
    if (fr.chunk_end) begin
      // open runs close at the frame count, then each lane flushes
      count = frame_bump(f);
      for (int s = 0; s < NUM_SPK; s++) begin
        if (run_on[s]) fold_run(s, run_begin[s], count);
        if (hold_on[s]) release_held(s);
      end
      clear_lanes();
    end else begin
      frame_cnt = frame_bump(f);
    end
    // run_end marks the final segment of this frame
    for (int i = 0; i < frame_segs.size(); i++) begin
      rec         = frame_segs[i];
      rec.run_end = (i == frame_segs.size() - 1);
      seg_exp_q.insert(seg_exp_q.size(), rec);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checker: samples both channels and the register port at the rising edge.
  // Outputs are checked before the new frame is predicted; a frame's first
  // segment cannot appear at the edge that accepts it.
  // Segments print as speaker/start/end/run_end.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : seg_check
    seg_rec_t got;
    seg_rec_t want;
    if (rst) begin
      thr_q     = '0;
      min_len_q = '0;
      gap_max_q = '0;
      clear_lanes();
      in_taken <= 1'b0;
    end else begin
      if (seg_ch.valid && seg_ch.ready) begin
        got.speaker     = seg_ch.speaker;
        got.start_frame = seg_ch.start_frame;
        got.end_frame   = seg_ch.end_frame;
        got.run_end     = seg_ch.run_end;
        if (seg_exp_q.size() == 0) begin
          $display("%0t: unexpected segment: expected none, got %0d/%0d/%0d/%0b",
                   $time, got.speaker, got.start_frame, got.end_frame, got.run_end);
          fails++;
        end else begin
          want = seg_exp_q.pop_front();
          if (got.speaker !== want.speaker || got.start_frame !== want.start_frame ||
              got.end_frame !== want.end_frame || got.run_end !== want.run_end) begin
            $display("%0t: segment differs: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                     $time, want.speaker, want.start_frame, want.end_frame, want.run_end,
                     got.speaker, got.start_frame, got.end_frame, got.run_end);
            fails++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_idx)
          CFG_THRESHOLD: thr_q     = cfg_wdata;
          CFG_MIN_LEN:   min_len_q = cfg_wdata;
          CFG_GAP_LIMIT: gap_max_q = cfg_wdata;
          default: ;  // spare index, no register behind it
        endcase
      end

      in_taken <= frame_ch.valid && frame_ch.ready;
      if (frame_ch.valid && frame_ch.ready) begin
        predict_segments(in_frame);
        frames_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame driver: bursts of random length with random gaps; a quarter of the
  // bursts run straight into the next one. Holds the item until it is taken.
  // ---------------------------------------------------------------------------
  frame_t frame_q[$];
  int     burst_left = 1;
  int     gap_left   = 0;

  always @(negedge clk) begin : frame_drive
    if (!rst && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (frame_q.size() > 0) begin
        in_frame <= frame_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Segment receiver pacing: a mode is held for a random span, then redrawn.
  // Bursty mode is ready about a quarter of the time; sparse takes one in four.
  // ---------------------------------------------------------------------------
  pace_t pace_mode = PACE_FREE;
  int    pace_span = 0;

  always @(negedge clk) begin : seg_pace
    if (pace_span == 0) begin
      pace_mode = pace_t'($urandom_range(0, 3));
      pace_span = $urandom_range(8, 64);
    end
    pace_span--;
    case (pace_mode)
      PACE_FREE:   out_ready <= 1'b1;
      PACE_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
      PACE_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= ((pace_span % 16) < 4);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  bit lane_act[NUM_SPK];
  int chunk_left = 0;

  task automatic send_frame(input frame_t fr);
    while (frame_q.size() >= QUEUE_DEPTH) @(posedge clk);
    frame_q.insert(frame_q.size(), fr);
    frames_queued++;
  endtask

  // Same score on every lane.
  function automatic frame_t flat_frame(input logic [SCORE_W-1:0] v, input bit chunk_end);
    frame_t fr;
    for (int s = 0; s < NUM_SPK; s++) fr.score[s] = v;
    fr.chunk_end = chunk_end;
    return fr;
  endfunction

  // Even lanes get one score, odd lanes the other.
  function automatic frame_t split_frame(input logic [SCORE_W-1:0] even_v,
                                         input logic [SCORE_W-1:0] odd_v,
                                         input bit chunk_end);
    frame_t fr;
    for (int s = 0; s < NUM_SPK; s++) fr.score[s] = (s % 2 == 0) ? even_v : odd_v;
    fr.chunk_end = chunk_end;
    return fr;
  endfunction

  // Score on the requested side of the current threshold, often at its edge.
  function automatic logic [SCORE_W-1:0] pick_score(input bit act);
    int lo;
    int hi;
    int v;
    if (act) begin
      lo = int'(thr_q);
      hi = 32767;
    end else begin
      lo = -32768;
      hi = int'(thr_q) - 1;
    end
    if (hi < lo) begin
      // threshold at the bottom: nothing can be inactive
      lo = int'(thr_q);
      hi = lo;
    end
    case ($urandom_range(0, 3))
      0:       v = lo;
      1:       v = hi;
      default: v = lo + int'($urandom_range(0, hi - lo));
    endcase
    return v[SCORE_W-1:0];
  endfunction

  // Mostly chunks of persistent per-speaker activity; one frame in ten is noise.
  task automatic send_random(input int n);
    frame_t      fr;
    logic [31:0] r;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        for (int s = 0; s < NUM_SPK; s++) begin
          r           = $urandom;
          fr.score[s] = r[SCORE_W-1:0];
        end
        fr.chunk_end = ($urandom_range(0, 7) == 0);
        if (fr.chunk_end) chunk_left = 0;
      end else begin
        for (int s = 0; s < NUM_SPK; s++) begin
          if ($urandom_range(0, 3) == 0) lane_act[s] = !lane_act[s];
          fr.score[s] = pick_score(lane_act[s]);
        end
        if (chunk_left == 0) chunk_left = $urandom_range(1, 20);
        chunk_left--;
        fr.chunk_end = (chunk_left == 0);
      end
      send_frame(fr);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender holds off until every frame is in and every segment is out, then
  // leaves time for frames that cause nothing to clear the pipeline.
  task automatic settle();
    @(negedge clk);
    while (frames_taken != frames_queued || seg_exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int r;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: threshold 0, no length floor, no merging.
    send_frame(flat_frame(16'h0000, 1'b0));   // at threshold counts as active
    send_frame(flat_frame(16'hFFFF, 1'b0));   // just below: all close, held
    send_frame(flat_frame(16'h8000, 1'b0));
    send_frame(flat_frame(16'h7FFF, 1'b0));
    send_frame(flat_frame(16'h7FFF, 1'b1));   // held out + open run: two per lane
    send_frame(flat_frame(16'hFFFF, 1'b1));   // empty chunk, nothing out
    send_frame(flat_frame(16'h0000, 1'b1));   // one-frame chunk, active throughout
    send_frame(split_frame(16'h7FFF, 16'h8000, 1'b0));
    send_frame(split_frame(16'h8000, 16'h7FFF, 1'b0));
    send_frame(flat_frame(16'h8000, 1'b0));
    send_frame(flat_frame(16'h5555, 1'b0));
    send_frame(flat_frame(16'hAAAA, 1'b0));
    send_frame(flat_frame(16'h0001, 1'b1));
    send_random(30);
    settle();

    // Top extremes: only the largest score is active, nothing is long enough.
    write_reg(CFG_THRESHOLD, 16'h7FFF);
    write_reg(CFG_MIN_LEN,   16'hFFFF);
    write_reg(CFG_GAP_LIMIT, 16'hFFFF);
    r = $urandom;
    write_reg(CFG_SPARE, r[CFG_W-1:0]);
    send_frame(flat_frame(16'h7FFF, 1'b0));
    send_frame(flat_frame(16'h7FFE, 1'b0));
    send_frame(flat_frame(16'h7FFF, 1'b1));
    send_random(15);
    settle();

    // Bottom threshold: every score is active, runs span the whole chunk.
    write_reg(CFG_THRESHOLD, 16'h8000);
    write_reg(CFG_MIN_LEN,   16'h0000);
    send_frame(flat_frame(16'h8000, 1'b0));
    send_frame(flat_frame(16'h1234, 1'b0));
    send_frame(flat_frame(16'h8000, 1'b1));
    send_random(10);
    settle();

    // Merge across a one-frame gap; a one-frame segment falls under the floor.
    write_reg(CFG_THRESHOLD, 16'h0000);
    write_reg(CFG_MIN_LEN,   16'd2);
    write_reg(CFG_GAP_LIMIT, 16'd1);
    send_frame(flat_frame(16'h0100, 1'b0));
    send_frame(flat_frame(16'hFF00, 1'b0));
    send_frame(flat_frame(16'h0100, 1'b0));
    send_frame(flat_frame(16'hFF00, 1'b0));
    send_frame(flat_frame(16'hFF00, 1'b1));
    send_frame(flat_frame(16'h0100, 1'b0));
    send_frame(flat_frame(16'hFF00, 1'b1));
    send_random(15);
    settle();

    // A few random settings around probability one half.
    repeat (3) begin
      r = int'($urandom_range(0, 1200)) - 600;
      write_reg(CFG_THRESHOLD, r[CFG_W-1:0]);
      r = int'($urandom_range(0, 3));
      write_reg(CFG_MIN_LEN, r[CFG_W-1:0]);
      r = int'($urandom_range(0, 3));
      write_reg(CFG_GAP_LIMIT, r[CFG_W-1:0]);
      send_random(12);
      settle();
    end

    if (fails == 0) begin
      $display("speaker_activity_segmenter: match");
    end else begin
      $display("speaker_activity_segmenter: mismatch");
    end
    $finish;
  end

  // Hard stop if the block hangs or drops segments.
  initial begin : watchdog
    #(LIMIT_TIME);
    $display("speaker_activity_segmenter: mismatch");
    $finish;
  end

endmodule
